[rtl/ctvs_pkg.sv]
`default_nettype none

package ctvs_pkg;

    // One result of the scan: the found flag and the value, or -1 when not found.
    typedef struct packed {
        logic               found;
        logic signed [31:0] value;
    } res_t;

    // Register indexes of the configuration write port.
    typedef enum logic [1:0] {
        REG_TAG_LOW    = 2'd0,
        REG_TAG_HIGH   = 2'd1,
        REG_TAG_LENGTH = 2'd2
    } cfg_reg_t;

    localparam logic signed [31:0] NOT_FOUND_VALUE = 32'shFFFF_FFFF;

endpackage

`default_nettype wire

[rtl/ctvs_parse.sv]
`default_nettype none

module ctvs_parse #(
    parameter int MAX_TAG_CHARS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step_en,
    input  wire logic [7:0]                    text_byte,
    input  wire logic                          end_of_file,
    input  wire logic [MAX_TAG_CHARS-1:0][7:0] tag_chars,
    input  wire logic [4:0]                    tag_length,
    output logic                               res_valid,
    output ctvs_pkg::res_t                     res
);

    // The tag count saturates one above the longest tag.
    localparam int CW = $clog2(MAX_TAG_CHARS + 2);
    localparam int IW = (MAX_TAG_CHARS > 1) ? $clog2(MAX_TAG_CHARS) : 1;

    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_VT     = 8'd11;
    localparam logic [7:0] CH_FF     = 8'd12;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_X_LOW  = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_A_LOW  = 8'h61;
    localparam logic [7:0] CH_F_LOW  = 8'h66;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_F_UP   = 8'h46;

    localparam logic [31:0] HEX_LIMIT = 32'h7FFF_FFFF;

    typedef struct packed {
        logic          skip;
        logic          matched;
        logic [CW-1:0] tag_cnt;
        logic          mismatch;
        logic [1:0]    val_pos;
        logic          hex;
        logic          neg;
        logic          stopped;
        logic [31:0]   acc;
        logic          hex_sat;
        logic          first_zero;
        logic          lead_done;
    } scan_t;

    scan_t scan_reg, scan_next;

    logic          dec_ok;
    logic          hex_ok;
    logic [3:0]    hex_val;
    logic [31:0]   acc_x10;
    logic [31:0]   hex_room;
    logic          cnt_lt_max;
    logic [7:0]    cmp_char;
    logic          len_ok;
    logic          res_valid_next;
    ctvs_pkg::res_t res_next;

    always_comb begin
        dec_ok = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
        hex_ok = 1'b1;
        if (dec_ok) begin
            hex_val = text_byte[3:0];
        end else if ((text_byte >= CH_A_LOW && text_byte <= CH_F_LOW) ||
                     (text_byte >= CH_A_UP && text_byte <= CH_F_UP)) begin
            hex_val = text_byte[3:0] + 4'd9;
        end else begin
            hex_ok  = 1'b0;
            hex_val = 4'd0;
        end
        acc_x10  = (scan_reg.acc << 3) + (scan_reg.acc << 1);
        hex_room = (HEX_LIMIT - 32'(hex_val)) >> 4;

        cnt_lt_max = scan_reg.tag_cnt < CW'(MAX_TAG_CHARS);
        cmp_char   = cnt_lt_max ? tag_chars[scan_reg.tag_cnt[IW-1:0]] : 8'h00;
        len_ok     = (tag_length != 5'd0) &&
                     (6'(tag_length) <= 6'(MAX_TAG_CHARS)) &&
                     (6'(scan_reg.tag_cnt) == 6'(tag_length));
    end

    always_comb begin
        scan_next      = scan_reg;
        res_valid_next = 1'b0;
        res_next.found = 1'b0;
        res_next.value = ctvs_pkg::NOT_FOUND_VALUE;

        if (end_of_file) begin
            res_valid_next = 1'b1;
            scan_next      = '0;
        end else if (text_byte == CH_CR) begin
            if (scan_reg.matched) begin
                res_valid_next = 1'b1;
                res_next.found = 1'b1;
                res_next.value = scan_reg.neg ? -scan_reg.acc : scan_reg.acc;
                scan_next      = '0;
            end else begin
                scan_next.skip     = 1'b0;
                scan_next.tag_cnt  = '0;
                scan_next.mismatch = 1'b0;
            end
        end else if (scan_reg.skip) begin
            // Inside a comment or a rejected line: wait for the carriage return.
        end else if (text_byte == CH_SLASH) begin
            scan_next.skip = 1'b1;
        end else if (text_byte == CH_SPACE || text_byte == CH_LF) begin
            // Spaces and line feeds are dropped everywhere.
        end else if (text_byte == CH_EQUALS) begin
            if (!scan_reg.matched) begin
                if (!scan_reg.mismatch && len_ok) begin
                    scan_next.matched = 1'b1;
                end else begin
                    scan_next.skip     = 1'b1;
                    scan_next.tag_cnt  = '0;
                    scan_next.mismatch = 1'b0;
                end
            end
        end else if (scan_reg.matched) begin
            if (scan_reg.val_pos != 2'd2) begin
                scan_next.val_pos = scan_reg.val_pos + 2'd1;
            end
            if (scan_reg.val_pos == 2'd0) begin
                scan_next.first_zero = (text_byte == CH_ZERO);
            end
            if (scan_reg.val_pos == 2'd1 && scan_reg.first_zero &&
                (text_byte == CH_X_LOW || text_byte == CH_X_UP)) begin
                scan_next.hex     = 1'b1;
                scan_next.acc     = '0;
                scan_next.neg     = 1'b0;
                scan_next.stopped = 1'b0;
            end else if (scan_reg.stopped) begin
                // Digits have ended; the rest of the value is ignored.
            end else if (scan_reg.hex) begin
                if (!hex_ok) begin
                    scan_next.stopped = 1'b1;
                end else if (scan_reg.hex_sat || scan_reg.acc > hex_room) begin
                    scan_next.hex_sat = 1'b1;
                    scan_next.acc     = HEX_LIMIT;
                end else begin
                    scan_next.acc = (scan_reg.acc << 4) + 32'(hex_val);
                end
            end else if (!scan_reg.lead_done &&
                         (text_byte == CH_TAB || text_byte == CH_VT ||
                          text_byte == CH_FF)) begin
                // Leading blanks before a decimal value are skipped.
            end else if (!scan_reg.lead_done &&
                         (text_byte == CH_PLUS || text_byte == CH_MINUS)) begin
                scan_next.lead_done = 1'b1;
                scan_next.neg       = (text_byte == CH_MINUS);
            end else if (dec_ok) begin
                scan_next.lead_done = 1'b1;
                scan_next.acc       = acc_x10 + 32'(text_byte[3:0]);
            end else begin
                scan_next.stopped = 1'b1;
            end
        end else begin
            if (!cnt_lt_max || text_byte != cmp_char) begin
                scan_next.mismatch = 1'b1;
            end
            if (scan_reg.tag_cnt <= CW'(MAX_TAG_CHARS)) begin
                scan_next.tag_cnt = scan_reg.tag_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
        end else if (step_en) begin
            scan_reg <= scan_next;
        end
    end

    assign res_valid = step_en && res_valid_next;
    assign res       = res_next;

endmodule

`default_nettype wire

[rtl/config_tag_value_scanner.sv]
// A result appears on the m_ side in the cycle after the byte that causes it is
// accepted, or later while an earlier result still waits in the output entry.
// Throughput: one byte per cycle while s_tready is high; the scan state updates in the
// cycle a byte is taken. A two-entry output buffer lets input go on while one result
// waits to be taken. Reset (aresetn low, synchronous) clears the tag registers and the
// scan state and empties both output entries.
`default_nettype none

module config_tag_value_scanner #(
    parameter int MAX_TAG_CHARS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_index,
    input  wire logic [63:0] cfg_wr_data,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // end_of_file
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] tag_value
    output logic             m_tuser    // [0] found flag
);

    logic [63:0] tag_low_reg;
    logic [63:0] tag_high_reg;
    logic [4:0]  tag_len_reg;

    logic [127:0]                   tag_all;
    logic [MAX_TAG_CHARS-1:0][7:0]  tag_chars;

    logic           step_en;
    logic           res_valid;
    ctvs_pkg::res_t res;

    logic           out_valid_reg;
    ctvs_pkg::res_t out_reg;
    logic           skid_valid_reg;
    ctvs_pkg::res_t skid_reg;
    logic           out_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_low_reg  <= '0;
            tag_high_reg <= '0;
            tag_len_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                ctvs_pkg::REG_TAG_LOW:    tag_low_reg  <= cfg_wr_data;
                ctvs_pkg::REG_TAG_HIGH:   tag_high_reg <= cfg_wr_data;
                ctvs_pkg::REG_TAG_LENGTH: tag_len_reg  <= cfg_wr_data[4:0];
                default: ;
            endcase
        end
    end

    assign tag_all   = {tag_high_reg, tag_low_reg};
    assign tag_chars = tag_all[8*MAX_TAG_CHARS-1:0];

    assign s_tready = !skid_valid_reg;
    assign step_en  = s_tvalid && s_tready;

    ctvs_parse #(
        .MAX_TAG_CHARS(MAX_TAG_CHARS)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .text_byte  (s_tdata),
        .end_of_file(s_tlast),
        .tag_chars  (tag_chars),
        .tag_length (tag_len_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign out_take = out_valid_reg && m_tready;

    // A new result goes to the output entry when it is free, else to the skid entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= res_valid;
            end else begin
                out_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (res_valid) begin
                    skid_reg <= res;
                end
            end else if (res_valid) begin
                out_reg <= res;
            end
        end else if (res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.value;
    assign m_tuser  = out_reg.found;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output entry is empty");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (out_valid_reg && skid_valid_reg))
        else $error("input stalled while the output buffer has room");

    a_eof_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> out_valid_reg)
        else $error("end of file did not produce a result");

    a_not_found_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.found) |-> (out_reg.value == ctvs_pkg::NOT_FOUND_VALUE))
        else $error("not-found result carries a value other than -1");

endmodule

`default_nettype wire
